@@ rtl/mm64b_pkg.sv @@
// Types, constants and the control program of the MurmurHash64B hasher.
`default_nettype none
package mm64b_pkg;

    localparam logic [31:0] MUR_M      = 32'h5bd1_e995;
    localparam logic [31:0] SEED_RESET = 32'hEE6B_27EB;
    localparam logic [2:0]  BYTES_FULL = 3'd4;

    localparam int unsigned PC_W = 3;
    typedef logic [PC_W-1:0] pc_t;

    // Entry points of the program.
    localparam pc_t PC_FULL = 3'd0;
    localparam pc_t PC_PART = 3'd3;
    localparam pc_t PC_FIN  = 3'd4;

    // Operand A of the multiply stage.
    typedef enum logic [1:0] {
        A_K  = 2'd0,
        A_H1 = 2'd1,
        A_H2 = 2'd2,
        A_HP = 2'd3     // half chosen by the word parity
    } a_sel_t;

    // Operand XORed into A (after a right shift) ahead of the multiply.
    typedef enum logic [1:0] {
        B_ZERO = 2'd0,
        B_K    = 2'd1,
        B_H1   = 2'd2,
        B_H2   = 2'd3
    } b_sel_t;

    // Register that takes the step result.
    typedef enum logic [1:0] {
        D_K  = 2'd0,
        D_H1 = 2'd1,
        D_H2 = 2'd2,
        D_HP = 2'd3
    } dst_t;

    // How the step counter moves on.
    typedef enum logic [1:0] {
        NX_SEQ  = 2'd0,     // next step
        NX_LAST = 2'd1,     // finalize if the item was last, else stop
        NX_EMIT = 2'd2,     // stop and present the hash
        NX_STOP = 2'd3
    } nxt_t;

    typedef struct packed {
        a_sel_t      a_sel;
        b_sel_t      b_sel;
        logic [4:0]  shamt;
        logic        post_xor;  // XOR the mixed word after the multiply
        dst_t        dst;
        logic        flip;      // toggle the word parity
        nxt_t        nxt;
    } ctl_t;

    // Sequencer request from the datapath side.
    typedef struct packed {
        logic start;
        pc_t  start_pc;
        logic start_last;
        logic stall;
    } seq_cmd_t;

    // Sequencer status.
    typedef struct packed {
        logic busy;
        logic step_en;
        logic ready;
    } seq_stat_t;

    function automatic ctl_t ctl_rom(input pc_t pc);
        ctl_t c;
        c = '{A_K, B_ZERO, 5'd0, 1'b0, D_K, 1'b0, NX_STOP};
        case (pc)
            3'd0: c = '{A_K,  B_ZERO, 5'd0,  1'b0, D_K,  1'b0, NX_SEQ};
            3'd1: c = '{A_K,  B_K,    5'd24, 1'b0, D_K,  1'b0, NX_SEQ};
            3'd2: c = '{A_HP, B_ZERO, 5'd0,  1'b1, D_HP, 1'b1, NX_LAST};
            3'd3: c = '{A_H2, B_K,    5'd0,  1'b0, D_H2, 1'b0, NX_LAST};
            3'd4: c = '{A_H1, B_H2,   5'd18, 1'b0, D_H1, 1'b0, NX_SEQ};
            3'd5: c = '{A_H2, B_H1,   5'd22, 1'b0, D_H2, 1'b0, NX_SEQ};
            3'd6: c = '{A_H1, B_H2,   5'd17, 1'b0, D_H1, 1'b0, NX_SEQ};
            3'd7: c = '{A_H2, B_H1,   5'd19, 1'b0, D_H2, 1'b0, NX_EMIT};
            default: c = '{A_K, B_ZERO, 5'd0, 1'b0, D_K, 1'b0, NX_STOP};
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/mm64b_seq.sv @@
// Step counter and control store of the MurmurHash64B hasher.
`default_nettype none
module mm64b_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mm64b_pkg::seq_cmd_t cmd,
    output mm64b_pkg::ctl_t          ctl,
    output mm64b_pkg::seq_stat_t     stat
);
    import mm64b_pkg::*;

    pc_t  pc_reg;
    logic busy_reg;
    logic last_reg;
    logic step_en;

    assign ctl     = ctl_rom(pc_reg);
    assign step_en = busy_reg & ~cmd.stall;

    assign stat.busy    = busy_reg;
    assign stat.step_en = step_en;
    // Take the next item when idle, or on the closing step of a non-last item.
    assign stat.ready   = ~busy_reg | (step_en & (ctl.nxt == NX_LAST) & ~last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= PC_FULL;
            busy_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            pc_reg   <= cmd.start_pc;
            busy_reg <= 1'b1;
            last_reg <= cmd.start_last;
        end
        else if (step_en)
        begin
            case (ctl.nxt)
                NX_SEQ:  pc_reg <= pc_reg + 1'b1;
                NX_LAST:
                begin
                    if (last_reg)
                        pc_reg <= PC_FIN;
                    else
                        busy_reg <= 1'b0;
                end
                NX_EMIT: busy_reg <= 1'b0;
                default: busy_reg <= 1'b0;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/murmur64b_hash.sv @@
// Top level of the MurmurHash64B message hasher.
`default_nettype none
// MurmurHash64B over a byte message streamed as 32-bit little-endian words.
// Each input transfer carries one word, its valid byte count (values above
// four count as four), the total message length and first/last marks; the
// first transfer of a message loads the first half with hash_seed XOR length
// and clears the second half. A full word and a partial word (1 to 3 bytes)
// each run their own steps, and the last word adds the finalization steps
// before the 64-bit hash appears on the output; a transfer with byte count 0
// and no last mark runs no step. Every step passes through the one shared
// 32x32 multiply-by-m stage, driven by an 8-entry control program, so the
// word after a non-last word is taken in the same cycle as the closing step
// of that word. The output hash is held in its own register, so a stalled
// result only blocks the final finalization step of the next message.
// hash_seed is written through cfg_wr_en/cfg_wr_data, by the user only while
// the block is idle, which the block itself does not enforce; it resets to 0xEE6B27EB.
module murmur64b_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: hash_seed
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    // message words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // data_word[31:0], byte_count[34:32],
                                            // total_length[65:35], zero[71:66]
    input  wire logic        s_axis_tuser,  // first_word
    input  wire logic        s_axis_tlast,  // last_word
    // hash results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata   // hash_value[63:0]
);
    import mm64b_pkg::*;

    // Unpacked input fields.
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic [30:0] total_length;
    logic [2:0]  count_sat;
    logic [31:0] word_masked;
    logic        accept;
    logic        has_work;

    // Hash state.
    logic [31:0] seed_reg;
    logic [31:0] h1_reg;
    logic [31:0] h2_reg;
    logic [31:0] k_reg;
    logic        parity_reg;
    logic [63:0] hash_reg;
    logic        out_valid_reg;

    // Datapath.
    ctl_t        ctl;
    seq_cmd_t    cmd;
    seq_stat_t   stat;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [31:0] prod;
    logic [31:0] res;
    logic        emit;

    assign data_word    = s_axis_tdata[31:0];
    assign byte_count   = s_axis_tdata[34:32];
    assign total_length = s_axis_tdata[65:35];

    // Saturate the byte count and drop bytes beyond it.
    always_comb
    begin
        count_sat   = (byte_count > BYTES_FULL) ? BYTES_FULL : byte_count;
        word_masked = data_word;
        case (count_sat)
            3'd0:    word_masked = 32'h0;
            3'd1:    word_masked = {24'h0, data_word[7:0]};
            3'd2:    word_masked = {16'h0, data_word[15:0]};
            3'd3:    word_masked = {8'h0, data_word[23:0]};
            default: word_masked = data_word;
        endcase
    end

    assign s_axis_tready = stat.ready;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign has_work      = (count_sat != 3'd0) | s_axis_tlast;

    // Choose the program entry from the kind of word.
    always_comb
    begin
        cmd.start      = accept & has_work;
        cmd.start_last = s_axis_tlast;
        if (count_sat == BYTES_FULL)
            cmd.start_pc = PC_FULL;
        else if (count_sat != 3'd0)
            cmd.start_pc = PC_PART;
        else
            cmd.start_pc = PC_FIN;
        // Hold the closing finalization step while the previous hash waits.
        cmd.stall = (ctl.nxt == NX_EMIT) & out_valid_reg & ~m_axis_tready;
    end

    mm64b_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ctl   (ctl),
        .stat  (stat)
    );

    // One step: (A ^ (B >> shamt)) * m, optionally XOR the mixed word after.
    always_comb
    begin
        case (ctl.a_sel)
            A_K:     opa = k_reg;
            A_H1:    opa = h1_reg;
            A_H2:    opa = h2_reg;
            A_HP:    opa = parity_reg ? h2_reg : h1_reg;
            default: opa = k_reg;
        endcase
        case (ctl.b_sel)
            B_ZERO:  opb = 32'h0;
            B_K:     opb = k_reg;
            B_H1:    opb = h1_reg;
            B_H2:    opb = h2_reg;
            default: opb = 32'h0;
        endcase
        prod = (opa ^ (opb >> ctl.shamt)) * MUR_M;
        res  = prod ^ (ctl.post_xor ? k_reg : 32'h0);
    end

    assign emit = stat.step_en & (ctl.nxt == NX_EMIT);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= SEED_RESET;
        else if (cfg_wr_en)
            seed_reg <= cfg_wr_data;
    end

    // Hash halves and word parity; a first word overrides the closing step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_reg     <= 32'h0;
            h2_reg     <= 32'h0;
            parity_reg <= 1'b0;
        end
        else
        begin
            if (stat.step_en)
            begin
                case (ctl.dst)
                    D_H1: h1_reg <= res;
                    D_H2: h2_reg <= res;
                    D_HP:
                    begin
                        if (parity_reg)
                            h2_reg <= res;
                        else
                            h1_reg <= res;
                    end
                    default: ;
                endcase
                if (ctl.flip)
                    parity_reg <= ~parity_reg;
            end
            if (accept && s_axis_tuser)
            begin
                h1_reg     <= seed_reg ^ {1'b0, total_length};
                h2_reg     <= 32'h0;
                parity_reg <= 1'b0;
            end
        end
    end

    // Word register: load the masked word, then hold the mixed value.
    always_ff @(posedge clk)
    begin
        if (accept)
            k_reg <= word_masked;
        else if (stat.step_en && ctl.dst == D_K)
            k_reg <= res;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            hash_reg <= {h1_reg, res};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = hash_reg;

`ifndef SYNTHESIS
    // A busy sequencer takes a new word only on the closing step of a word.
    a_ready_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.busy && s_axis_tready) |-> (ctl.nxt == NX_LAST))
        else $error("input taken in the middle of a program");

    // The closing finalization step always produces a pending hash.
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_axis_tvalid)
        else $error("hash not presented after finalization");

    // A new hash comes only out of a running program.
    a_emit_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(stat.busy))
        else $error("hash presented while idle");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_murmur64b_hash.sv @@
// Self-checking testbench for the MurmurHash64B message hasher.
`default_nettype none
module tb_murmur64b_hash;
    import mm64b_pkg::*;

    // Cycle budget and drain timing.
    localparam int unsigned RUN_LIMIT      = 400000;
    localparam int unsigned SETTLE_CYCLES  = 16;    // > full word + finalize + output
    localparam int unsigned RX_HOLD_CYCLES = 400;   // long sink back-pressure stretch
    localparam int unsigned PHASE_WORDS    = 265;   // 4 phases, at least 1060 words in all

    // One message word as it travels on the slave side.
    typedef struct {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        first_word;
        logic        last_word;
        logic [30:0] total_length;
    } msg_word_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [31:0] cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;    // data_word[31:0], byte_count[34:32],
                                        // total_length[65:35], zero[71:66]
    logic        s_axis_tuser  = 1'b0;  // first_word
    logic        s_axis_tlast  = 1'b0;  // last_word
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // hash_value[63:0]

    // Words waiting to be offered, and hashes waiting to come out.
    msg_word_t   word_pending_q[$];
    logic [63:0] hash_exp_q[$];

    // Shadow of the hasher state, updated on every accepted transfer.
    logic [31:0] model_seed = SEED_RESET;
    logic [31:0] model_h1   = '0;
    logic [31:0] model_h2   = '0;
    logic        model_odd  = 1'b0;

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    bit          rx_hold_arm  = 1'b0;
    bit          rx_hold_done = 1'b0;
    int unsigned rx_hold_left = 0;
    int unsigned err_count    = 0;
    int unsigned cycle_count  = 0;
    int unsigned words_queued = 0;
    msg_word_t   drv_word;
    msg_word_t   mon_word;
    logic [63:0] mon_hash;
    logic [63:0] mon_exp;

    murmur64b_hash u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Word mix: multiply, fold the top byte down, multiply again.
    function automatic logic [31:0] mix_word32(input logic [31:0] k);
        logic [31:0] t;
        t = k * MUR_M;
        t = t ^ (t >> 24);
        return t * MUR_M;
    endfunction

    // Absorb one word into the shadow state; return 1 with the hash when the
    // word closes a message.
    function automatic bit absorb_word(input msg_word_t w, output logic [63:0] hv);
        logic [2:0]  n;
        logic [31:0] mask;
        n  = (w.byte_count > BYTES_FULL) ? BYTES_FULL : w.byte_count;
        hv = '0;
        if (w.first_word)
        begin
            model_h1  = model_seed ^ {1'b0, w.total_length};
            model_h2  = '0;
            model_odd = 1'b0;
        end
        if (n == BYTES_FULL)
        begin
            if (!model_odd)
                model_h1 = (model_h1 * MUR_M) ^ mix_word32(w.data_word);
            else
                model_h2 = (model_h2 * MUR_M) ^ mix_word32(w.data_word);
            model_odd = ~model_odd;
        end
        else if (n != 3'd0)
        begin
            // tail bytes: drop anything above the byte count
            mask     = (32'h1 << (8 * n)) - 32'h1;
            model_h2 = (model_h2 ^ (w.data_word & mask)) * MUR_M;
        end
        if (!w.last_word)
            return 1'b0;
        model_h1 = (model_h1 ^ (model_h2 >> 18)) * MUR_M;
        model_h2 = (model_h2 ^ (model_h1 >> 22)) * MUR_M;
        model_h1 = (model_h1 ^ (model_h2 >> 17)) * MUR_M;
        model_h2 = (model_h2 ^ (model_h1 >> 19)) * MUR_M;
        hv = {model_h1, model_h2};
        return 1'b1;
    endfunction

    function automatic void put_word(input logic [31:0] d, input logic [2:0] n,
                                     input logic f, input logic l, input logic [30:0] len);
        msg_word_t w;
        w.data_word    = d;
        w.byte_count   = n;
        w.first_word   = f;
        w.last_word    = l;
        w.total_length = len;
        word_pending_q.insert(word_pending_q.size(), w);
    endfunction

    // Queue one message of nbytes bytes with random content. Optionally lie
    // about the length, drop the closing mark, oversize full-word counts and
    // slip in empty words that carry nothing.
    task automatic queue_message(input int unsigned nbytes, input bit lie_len,
                                 input bit drop_last);
        int unsigned left;
        logic [2:0]  n;
        logic [30:0] len;
        bit          first;
        left  = nbytes;
        first = 1'b1;
        len   = lie_len ? 31'($urandom) : 31'(nbytes);
        do
        begin
            if (left >= 4)
            begin
                n    = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : BYTES_FULL;
                left = left - 4;
            end
            else
            begin
                n    = 3'(left);
                left = 0;
            end
            put_word($urandom, n, first, (left == 0) && !drop_last, len);
            words_queued++;
            if (left != 0 && $urandom_range(19) == 0)
                put_word($urandom, 3'd0, 1'b0, 1'b0, 31'($urandom));
            first = 1'b0;
        end
        while (left != 0);
    endtask

    // Wait until every word is accepted and every hash has come out, then let
    // the block settle before anything else touches it.
    task automatic drain_block();
        while (word_pending_q.size() != 0 || s_axis_tvalid || hash_exp_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_seed = v;
    endtask

    // Source side: advance to the next word once the current one transfers,
    // idle at random per the phase rate.
    always @(posedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (word_pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                drv_word = word_pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'b0, drv_word.total_length, drv_word.byte_count,
                                  drv_word.data_word};
                s_axis_tuser  <= drv_word.first_word;
                s_axis_tlast  <= drv_word.last_word;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: random stalls, plus one long hold-off counted here so the
    // hasher backs up into its input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold_left != 0)
            begin
                rx_hold_left  <= rx_hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (rx_hold_arm && !rx_hold_done)
            begin
                rx_hold_left  <= RX_HOLD_CYCLES;
                rx_hold_done  <= 1'b1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Monitor: check each hash transfer against the oldest prediction, then
    // predict from the word that transfers at this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (hash_exp_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: hash_value expected none, got %h", $time, m_axis_tdata);
                end
                else
                begin
                    mon_exp = hash_exp_q.pop_front();
                    if (mon_exp !== m_axis_tdata)
                    begin
                        err_count++;
                        $display("%0t: hash_value expected %h, got %h",
                                 $time, mon_exp, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                mon_word.data_word    = s_axis_tdata[31:0];
                mon_word.byte_count   = s_axis_tdata[34:32];
                mon_word.total_length = s_axis_tdata[65:35];
                mon_word.first_word   = s_axis_tuser;
                mon_word.last_word    = s_axis_tlast;
                if (absorb_word(mon_word, mon_hash))
                    hash_exp_q.insert(hash_exp_q.size(), mon_hash);
            end
        end
    end

    // Watchdog: a hang or a lost hash ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("murmur64b_hash: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned tx_pct_tab[4];
        int unsigned rx_pct_tab[4];
        logic [31:0] seed_tab[4];
        int unsigned r;
        bit          mid_paused;
        tx_pct_tab = '{0, 49, 0, 37};
        rx_pct_tab = '{0, 0, 49, 37};
        seed_tab   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'($urandom), SEED_RESET ^ 32'($urandom)};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset seed.
        put_word(32'hA5A5_5A5A, BYTES_FULL, 1'b0, 1'b1, 31'd0);     // no opening mark after reset
        put_word(32'h0000_0000, 3'd0, 1'b1, 1'b1, 31'd0);           // empty message
        put_word(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, 31'h7FFF_FFFF);   // empty, max length
        put_word(32'hFFFF_FFFF, 3'd1, 1'b1, 1'b1, 31'd1);           // masked tails
        put_word(32'hFFFF_FFFF, 3'd2, 1'b1, 1'b1, 31'd2);
        put_word(32'hFFFF_FFFF, 3'd3, 1'b1, 1'b1, 31'd3);
        put_word(32'hFFFF_FFFF, BYTES_FULL, 1'b1, 1'b1, 31'd4);
        put_word(32'h0000_0000, BYTES_FULL, 1'b1, 1'b0, 31'd8);     // both halves fed
        put_word(32'h8000_0001, BYTES_FULL, 1'b0, 1'b1, 31'd8);
        put_word(32'h0403_0201, BYTES_FULL, 1'b1, 1'b0, 31'd11);
        put_word(32'h0807_0605, BYTES_FULL, 1'b0, 1'b0, 31'd11);
        put_word(32'hDE0B_0A09, 3'd3, 1'b0, 1'b1, 31'd11);
        put_word(32'h1234_5678, 3'd7, 1'b1, 1'b0, 31'd9);           // oversize counts saturate
        put_word(32'h9ABC_DEF0, 3'd5, 1'b0, 1'b0, 31'd9);
        put_word(32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 31'd9);           // carries nothing
        put_word(32'h0000_00C3, 3'd1, 1'b0, 1'b1, 31'd9);
        put_word(32'h5566_7788, 3'd2, 1'b1, 1'b0, 31'd6);           // tail ahead of a full word
        put_word(32'h1122_3344, BYTES_FULL, 1'b0, 1'b1, 31'd6);
        put_word(32'h0F0F_F0F0, BYTES_FULL, 1'b0, 1'b1, 31'd0);     // continue after finalize
        put_word(32'h3C3C_C3C3, BYTES_FULL, 1'b1, 1'b0, 31'h5555_5555); // length disagrees
        put_word(32'h0000_0000, 3'd0, 1'b0, 1'b1, 31'h2AAA_AAAA);   // close with no bytes
        drain_block();

        for (int p = 0; p < 4; p++)
        begin
            write_seed(seed_tab[p]);
            tx_idle_pct  = tx_pct_tab[p];
            rx_stall_pct = rx_pct_tab[p];
            // Full-rate source against a long sink hold-off in the sink-stall phase.
            if (p == 2)
                rx_hold_arm = 1'b1;
            words_queued = 0;
            mid_paused   = 1'b0;
            while (words_queued < PHASE_WORDS)
            begin
                r = $urandom_range(99);
                if (r < 82)
                    queue_message(($urandom_range(7) != 0) ? $urandom_range(24)
                                                           : $urandom_range(120, 25),
                                  $urandom_range(9) == 0, $urandom_range(19) == 0);
                else
                begin
                    put_word($urandom, 3'($urandom_range(7)), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 31'($urandom));
                    words_queued++;
                end
                // Pause the source mid-phase until every hash is back.
                if (!mid_paused && words_queued >= PHASE_WORDS / 2)
                begin
                    drain_block();
                    mid_paused = 1'b1;
                end
            end
            drain_block();
        end

        if (err_count == 0 && hash_exp_q.size() == 0)
            $display("murmur64b_hash: match");
        else
            $display("murmur64b_hash: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
